// ===== rtl/core/ialm_pkg.sv =====
// Shared types and constants of the inverse arc-length mapper.
package ialm_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int ARC_W       = 47;
  localparam int LEN_W       = 48;
  localparam int WIDE_W      = 96;
  localparam int OPB_W       = 48;
  localparam int STEP_W      = 7;

  localparam logic [ARC_W-1:0] ARC_MAX = {ARC_W{1'b1}};

  // Item kinds on the input tuser
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_NORM  = 2'd1;
  localparam logic [1:0] FN_MAP   = 2'd2;
  localparam logic [1:0] FN_UNDEF = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_X_ORDER    = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_BAD_TARGET = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    AR_MUL  = 2'd0,
    AR_DIV  = 2'd1,
    AR_SQRT = 2'd2
  } ar_op_t;

  typedef struct packed {
    logic              start;
    ar_op_t            op;
    logic [WIDE_W-1:0] a;
    logic [OPB_W-1:0]  b;
  } ar_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [WIDE_W-1:0] res;
  } ar_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_x_en;
    logic              wr_arc_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_x;
    logic [ARC_W-1:0]  wr_arc;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SQ1, S_SQ2, S_SQRT,
    S_NRD, S_NWAIT, S_NMUL, S_NDIV,
    S_HTRY, S_RD0, S_RD1, S_RD2,
    S_BS0, S_BS1, S_BSL, S_BSC,
    S_ISTART, S_IMUL, S_IDIV, S_FINISH
  } state_t;

endpackage

// ===== rtl/core/inverse_arc_length_mapper_top.sv =====
// Top level of the inverse arc-length mapper: sequencer, state and output register.
//
// Usage: one item on the s_ side per command; s_tuser selects add sample, normalize
// or map. Every item gives exactly one result item on the m_ side.
// The block takes one item at a time: s_tready is high only while the sequencer
// idles, and it rises again as soon as a result sits in the output register, so
// the next item is taken while the receiver still holds off m_tready.
// The work runs on the shared iterative unit (multiply, divide and square root) and
// the registered memory read port:
//   add sample: two squares and a root, unless rejected early or the first sample;
//   map: a search over the segments, then the interpolation;
//   normalize: a multiply and a divide per stored sample, walking the whole store.
// Reset clears the sample count, hint and previous f(x); the memories are
// not cleared and need no clearing pass, since only written entries are read.
// A stalled receiver holds the result in the output register; a finished item
// waits there until the register is free.
module inverse_arc_length_mapper_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // sample_x [31:0], sample_fx [63:32], length_value [111:64]
  input  logic [111:0] s_tdata,
  // func [1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // mapped_x [31:0], status [33:32], total_length [80:34], sample_count [91:81], zeros
  output logic [95:0]  m_tdata
);
  import ialm_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]        count, count_next;
  logic signed [31:0]      last_x, last_x_next;
  logic [ARC_W-1:0]        last_arc, last_arc_next;
  logic signed [31:0]      prev_fx, prev_fx_next;
  logic [ADDR_W-1:0]       hint, hint_next;
  logic                    hint_bw, hint_bw_next;

  logic [1:0]              func_r;
  logic signed [31:0]      x_r, fx_r;
  logic signed [LEN_W-1:0] len_r;

  stat_t                   status_r, status_next;
  logic [31:0]             mapped_r, mapped_next;
  logic [ADDR_W-1:0]       idx, idx_next;
  logic [ARC_W-1:0]        total_r, total_next;
  logic [ADDR_W-1:0]       seg, seg_next;
  logic [1:0]              k, k_next;
  logic                    probe, probe_next;
  logic [ARC_W-1:0]        a0, a0_next, a1, a1_next, larc, larc_next;
  logic signed [31:0]      x0, x0_next, x1, x1_next;
  logic [63:0]             s1, s1_next;
  logic [ADDR_W-1:0]       lft, lft_next, rgt, rgt_next;
  logic                    neg, neg_next;

  mem_req_t                mreq;
  ar_req_t                 areq;
  ar_rsp_t                 arsp;
  logic [31:0]             rd_x;
  logic [ARC_W-1:0]        rd_arc;

  logic                    out_free;

  ialm_store u_store (
    .clk    (clk),
    .req    (mreq),
    .rd_x   (rd_x),
    .rd_arc (rd_arc)
  );

  ialm_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Shared combinational terms
  logic [32:0]        dx33, dy33, ady33;
  logic signed [11:0] cand;
  logic               cand_ok;
  logic signed [48:0] a49, l49, r49, marc49, d1, d2, num49;
  logic signed [47:0] den;
  logic [47:0]        mag;
  logic [ADDR_W:0]    mid_sum;
  logic [ADDR_W-1:0]  mid;
  logic               holds;
  logic [34:0]        q35;
  logic signed [36:0] xr37;
  logic [47:0]        arc_sum;
  logic [ARC_W-1:0]   nq;

  always_comb begin
    dx33    = {x_r[31], x_r} - {last_x[31], last_x};
    dy33    = {fx_r[31], fx_r} - {prev_fx[31], prev_fx};
    ady33   = dy33[32] ? (33'd0 - dy33) : dy33;
    unique case (k)
      2'd1:    cand = $signed({2'b00, hint}) + (hint_bw ? -12'sd1 : 12'sd1);
      2'd2:    cand = $signed({2'b00, hint}) - (hint_bw ? -12'sd1 : 12'sd1);
      default: cand = $signed({2'b00, hint});
    endcase
    cand_ok = !cand[11] && (({1'b0, cand[10:0]} + 12'd1) < {1'b0, count});
    a49     = {len_r[LEN_W-1], len_r};
    l49     = $signed({2'b00, a0});
    r49     = $signed({2'b00, rd_arc});
    marc49  = $signed({2'b00, rd_arc});
    d1      = a49 - marc49;
    d2      = a49 - $signed({2'b00, larc});
    holds   = (a49 >= l49 && a49 <= r49) || (a49 <= l49 && a49 >= r49);
    den     = $signed({1'b0, a1}) - $signed({1'b0, a0});
    num49   = a49 - l49;
    mag     = num49[48] ? 48'(49'd0 - num49) : num49[47:0];
    mid_sum = {1'b0, lft} + {1'b0, rgt};
    mid     = mid_sum[ADDR_W:1];
    q35     = ((|arsp.res[95:35]) || (arsp.res[34:0] > 35'h4_0000_0000))
              ? 35'h4_0000_0000 : arsp.res[34:0];
    xr37    = neg ? ($signed({{5{x0[31]}}, x0}) - $signed({2'b00, q35}))
                  : ($signed({{5{x0[31]}}, x0}) + $signed({2'b00, q35}));
    arc_sum = {1'b0, last_arc} + {14'd0, arsp.res[33:0]};
    nq      = (|arsp.res[95:47]) ? ARC_MAX : arsp.res[46:0];
  end

  // Sequencer: next state, register updates, memory and unit requests
  always_comb begin
    state_next    = state;
    count_next    = count;
    last_x_next   = last_x;
    last_arc_next = last_arc;
    prev_fx_next  = prev_fx;
    hint_next     = hint;
    hint_bw_next  = hint_bw;
    status_next   = status_r;
    mapped_next   = mapped_r;
    idx_next      = idx;
    total_next    = total_r;
    seg_next      = seg;
    k_next        = k;
    probe_next    = probe;
    a0_next       = a0;
    a1_next       = a1;
    x0_next       = x0;
    x1_next       = x1;
    larc_next     = larc;
    s1_next       = s1;
    lft_next      = lft;
    rgt_next      = rgt;
    neg_next      = neg;
    mreq          = '0;
    areq          = '0;
    areq.op       = AR_MUL;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        status_next = STAT_OK;
        mapped_next = '0;
        state_next  = S_FINISH;
        case (func_r)
          FN_ADD: begin
            if (count >= CNT_W'(MAX_SAMPLES)) begin
              status_next = STAT_FULL;
            end else if (count != '0 && x_r <= last_x) begin
              status_next = STAT_X_ORDER;
            end else if (count == '0) begin
              mreq.wr_x_en   = 1'b1;
              mreq.wr_arc_en = 1'b1;
              mreq.wr_addr   = '0;
              mreq.wr_x      = x_r;
              mreq.wr_arc    = '0;
              count_next     = CNT_W'(1);
              last_x_next    = x_r;
              last_arc_next  = '0;
              prev_fx_next   = fx_r;
            end else begin
              areq.start = 1'b1;
              areq.op    = AR_MUL;
              areq.a     = {64'd0, dx33[31:0]};
              areq.b     = {16'd0, dx33[31:0]};
              state_next = S_SQ1;
            end
          end
          FN_NORM: begin
            if (count < CNT_W'(2)) begin
              status_next = STAT_OK;
            end else if (len_r <= 0) begin
              status_next = STAT_BAD_TARGET;
            end else if (last_arc != '0) begin
              idx_next   = '0;
              total_next = last_arc;
              state_next = S_NRD;
            end
          end
          FN_MAP: begin
            if (count == '0) begin
              mapped_next = '0;
            end else if (count == CNT_W'(1)) begin
              mapped_next = last_x;
            end else if (len_r < 0) begin
              seg_next     = '0;
              hint_bw_next = (hint != '0);
              hint_next    = '0;
              probe_next   = 1'b0;
              state_next   = S_RD0;
            end else if (a49 > $signed({2'b00, last_arc})) begin
              seg_next     = ADDR_W'(count - CNT_W'(2));
              hint_bw_next = ADDR_W'(count - CNT_W'(2)) < hint;
              hint_next    = ADDR_W'(count - CNT_W'(2));
              probe_next   = 1'b0;
              state_next   = S_RD0;
            end else begin
              k_next     = '0;
              state_next = S_HTRY;
            end
          end
          default: begin
            status_next = STAT_OK;
          end
        endcase
      end

      // Add: square dy, then root of the sum of squares
      S_SQ1: begin
        if (arsp.done) begin
          s1_next    = arsp.res[63:0];
          areq.start = 1'b1;
          areq.op    = AR_MUL;
          areq.a     = {64'd0, ady33[31:0]};
          areq.b     = {16'd0, ady33[31:0]};
          state_next = S_SQ2;
        end
      end

      S_SQ2: begin
        if (arsp.done) begin
          areq.start = 1'b1;
          areq.op    = AR_SQRT;
          areq.a     = {31'd0, ({1'b0, s1} + {1'b0, arsp.res[63:0]})};
          state_next = S_SQRT;
        end
      end

      S_SQRT: begin
        if (arsp.done) begin
          mreq.wr_x_en   = 1'b1;
          mreq.wr_arc_en = 1'b1;
          mreq.wr_addr   = count[ADDR_W-1:0];
          mreq.wr_x      = x_r;
          mreq.wr_arc    = arc_sum[47] ? ARC_MAX : arc_sum[ARC_W-1:0];
          last_arc_next  = arc_sum[47] ? ARC_MAX : arc_sum[ARC_W-1:0];
          last_x_next    = x_r;
          prev_fx_next   = fx_r;
          count_next     = count + CNT_W'(1);
          state_next     = S_FINISH;
        end
      end

      // Normalize: walk the store, rescale each arc
      S_NRD: begin
        mreq.rd_addr = idx;
        state_next   = S_NWAIT;
      end

      S_NWAIT: begin
        areq.start = 1'b1;
        areq.op    = AR_MUL;
        areq.a     = {49'd0, rd_arc};
        areq.b     = len_r;
        state_next = S_NMUL;
      end

      S_NMUL: begin
        if (arsp.done) begin
          areq.start = 1'b1;
          areq.op    = AR_DIV;
          areq.a     = arsp.res + {49'd0, 1'b0, total_r[ARC_W-1:1]};
          areq.b     = {1'b0, total_r};
          state_next = S_NDIV;
        end
      end

      S_NDIV: begin
        if (arsp.done) begin
          mreq.wr_arc_en = 1'b1;
          mreq.wr_addr   = idx;
          mreq.wr_arc    = nq;
          if ({1'b0, idx} == count - CNT_W'(1)) begin
            last_arc_next = nq;
            state_next    = S_FINISH;
          end else begin
            idx_next   = idx + ADDR_W'(1);
            state_next = S_NRD;
          end
        end
      end

      // Map: try the hinted segment and its neighbors
      S_HTRY: begin
        if (k == 2'd3) begin
          state_next = S_BS0;
        end else if (cand_ok) begin
          seg_next   = cand[ADDR_W-1:0];
          probe_next = 1'b1;
          state_next = S_RD0;
        end else begin
          k_next = k + 2'd1;
        end
      end

      S_RD0: begin
        mreq.rd_addr = seg;
        state_next   = S_RD1;
      end

      S_RD1: begin
        mreq.rd_addr = seg + ADDR_W'(1);
        a0_next      = rd_arc;
        x0_next      = rd_x;
        state_next   = S_RD2;
      end

      S_RD2: begin
        a1_next = rd_arc;
        x1_next = rd_x;
        if (!probe) begin
          state_next = S_ISTART;
        end else if (holds) begin
          if (k != 2'd0) begin
            hint_bw_next = seg < hint;
            hint_next    = seg;
          end
          state_next = S_ISTART;
        end else begin
          k_next     = k + 2'd1;
          state_next = S_HTRY;
        end
      end

      // Map: binary search over the arc lengths
      S_BS0: begin
        mreq.rd_addr = '0;
        lft_next     = '0;
        rgt_next     = ADDR_W'(count - CNT_W'(1));
        state_next   = S_BS1;
      end

      S_BS1: begin
        larc_next  = rd_arc;
        state_next = S_BSL;
      end

      S_BSL: begin
        if (({1'b0, lft} + (ADDR_W+1)'(1)) < {1'b0, rgt}) begin
          mreq.rd_addr = mid;
          state_next   = S_BSC;
        end else begin
          seg_next     = lft;
          hint_bw_next = lft < hint;
          hint_next    = lft;
          probe_next   = 1'b0;
          state_next   = S_RD0;
        end
      end

      S_BSC: begin
        if (d1 == 0 || d2 == 0 || (d1[48] != d2[48])) begin
          rgt_next = mid;
        end else begin
          lft_next  = mid;
          larc_next = rd_arc;
        end
        state_next = S_BSL;
      end

      // Map: interpolate x on the chosen segment
      S_ISTART: begin
        if (den[47] || den == 0) begin
          mapped_next = x0;
          state_next  = S_FINISH;
        end else begin
          neg_next   = num49[48];
          areq.start = 1'b1;
          areq.op    = AR_MUL;
          areq.a     = {48'd0, mag};
          areq.b     = {16'd0, 32'(x1 - x0)};
          state_next = S_IMUL;
        end
      end

      S_IMUL: begin
        if (arsp.done) begin
          areq.start = 1'b1;
          areq.op    = AR_DIV;
          areq.a     = arsp.res + {48'd0, 1'b0, den[47:1]};
          areq.b     = den;
          state_next = S_IDIV;
        end
      end

      S_IDIV: begin
        if (arsp.done) begin
          if (xr37 > 37'sd2147483647) begin
            mapped_next = 32'h7FFF_FFFF;
          end else if (xr37 < -37'sd2147483648) begin
            mapped_next = 32'h8000_0000;
          end else begin
            mapped_next = xr37[31:0];
          end
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      prev_fx  <= '0;
      hint     <= '0;
      hint_bw  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      prev_fx <= prev_fx_next;
      hint    <= hint_next;
      hint_bw <= hint_bw_next;
      if (state == S_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_r <= s_tuser;
      x_r    <= s_tdata[31:0];
      fx_r   <= s_tdata[63:32];
      len_r  <= s_tdata[111:64];
    end
    last_x   <= last_x_next;
    last_arc <= last_arc_next;
    status_r <= status_next;
    mapped_r <= mapped_next;
    idx      <= idx_next;
    total_r  <= total_next;
    seg      <= seg_next;
    k        <= k_next;
    probe    <= probe_next;
    a0       <= a0_next;
    a1       <= a1_next;
    x0       <= x0_next;
    x1       <= x1_next;
    larc     <= larc_next;
    s1       <= s1_next;
    lft      <= lft_next;
    rgt      <= rgt_next;
    neg      <= neg_next;
    if (state == S_FINISH && out_free) begin
      m_tdata <= {4'd0, count, ((count < CNT_W'(2)) ? {ARC_W{1'b0}} : last_arc),
                  status_r, mapped_r};
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> ({1'b0, hint} <= count - CNT_W'(2)))
    else $error("hint segment outside stored samples");

  a_unit_idle: assert property (@(posedge clk) disable iff (rst)
    areq.start |-> !arsp.busy)
    else $error("arithmetic unit started while busy");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result issued outside finish");

endmodule

// ===== rtl/core/ialm_store.sv =====
// Sample store: x and arc-length memories with one write and one registered read port.
module ialm_store (
  input  logic                            clk,
  input  ialm_pkg::mem_req_t              req,
  output logic [31:0]                     rd_x,
  output logic [ialm_pkg::ARC_W-1:0]      rd_arc
);
  import ialm_pkg::*;

  logic [31:0]      x_mem   [MAX_SAMPLES];
  logic [ARC_W-1:0] arc_mem [MAX_SAMPLES];

  // Write the addressed entries
  always_ff @(posedge clk) begin
    if (req.wr_x_en) begin
      x_mem[req.wr_addr] <= req.wr_x;
    end
    if (req.wr_arc_en) begin
      arc_mem[req.wr_addr] <= req.wr_arc;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_x   <= x_mem[req.rd_addr];
    rd_arc <= arc_mem[req.rd_addr];
  end

endmodule

// ===== rtl/core/ialm_arith.sv =====
// Shared iterative unit: shift-add multiply, restoring divide, rounded square root.
module ialm_arith (
  input  logic              clk,
  input  logic              rst,
  input  ialm_pkg::ar_req_t req,
  output ialm_pkg::ar_rsp_t rsp
);
  import ialm_pkg::*;

  localparam int MUL_STEPS  = OPB_W;
  localparam int DIV_STEPS  = WIDE_W;
  localparam int SQRT_STEPS = 33;
  localparam int RT_W       = 34;

  ar_op_t             op;
  logic               busy;
  logic               done;
  logic [STEP_W-1:0]  cnt;
  logic [WIDE_W-1:0]  p;
  logic [48:0]        r;
  logic [RT_W-1:0]    rt;
  logic [OPB_W-1:0]   b;

  logic [48:0]        mul_sum;
  logic [48:0]        div_r2;
  logic               div_ge;
  logic [48:0]        sq_r2;
  logic [48:0]        sq_trial;
  logic               sq_ge;
  logic [RT_W-1:0]    sq_res;

  // Step datapaths
  always_comb begin
    mul_sum  = {1'b0, p[WIDE_W-1:OPB_W]} + (p[0] ? {1'b0, b} : 49'd0);
    div_r2   = {r[47:0], p[WIDE_W-1]};
    div_ge   = div_r2 >= {1'b0, b};
    sq_r2    = {r[46:0], p[WIDE_W-1:WIDE_W-2]};
    sq_trial = {13'd0, rt, 2'b01};
    sq_ge    = sq_r2 >= sq_trial;
    sq_res   = rt + RT_W'(r > {15'd0, rt});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= AR_MUL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        unique case (req.op)
          AR_MUL:  cnt <= STEP_W'(MUL_STEPS - 1);
          AR_DIV:  cnt <= STEP_W'(DIV_STEPS - 1);
          AR_SQRT: cnt <= STEP_W'(SQRT_STEPS - 1);
          default: cnt <= '0;
        endcase
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      r  <= '0;
      rt <= '0;
      unique case (req.op)
        AR_MUL: begin
          p <= {{(WIDE_W-OPB_W){1'b0}}, req.b};
          b <= req.a[OPB_W-1:0];
        end
        AR_DIV: begin
          p <= req.a;
          b <= req.b;
        end
        AR_SQRT: begin
          p <= {req.a[65:0], 30'd0};
          b <= req.b;
        end
        default: begin
          p <= req.a;
          b <= req.b;
        end
      endcase
    end else if (busy) begin
      unique case (op)
        AR_MUL: begin
          p <= {mul_sum, p[OPB_W-1:1]};
        end
        AR_DIV: begin
          r <= div_ge ? div_r2 - {1'b0, b} : div_r2;
          p <= {p[WIDE_W-2:0], div_ge};
        end
        AR_SQRT: begin
          r  <= sq_ge ? sq_r2 - sq_trial : sq_r2;
          rt <= {rt[RT_W-2:0], sq_ge};
          p  <= {p[WIDE_W-3:0], 2'b00};
        end
        default: begin
          p <= p;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.res  = (op == AR_SQRT) ? {{(WIDE_W-RT_W){1'b0}}, sq_res} : p;

endmodule
